// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever cond holds at an edge, prop must hold at the same edge.
`define ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Whenever cond holds at an edge, prop must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/ptt_pkg.sv =====
// Shared constants and types of the pan/tilt tracking step.
package ptt_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAME_BITS = 12;
  localparam int GAIN_BITS  = 16;
  localparam int ANGLE_BITS = 17;
  localparam int PULSE_BITS = 21;

  // Error magnitude times gain, the dividend of the serial divider.
  localparam int PROD_BITS = COORD_BITS + GAIN_BITS;
  localparam int CNT_BITS  = $clog2(PROD_BITS);
  localparam int SUM_BITS  = ANGLE_BITS + 2;

  localparam int ANGLE_LIMIT = 45000;
  localparam int OFF_BITS    = 17;

  // Pulse = PULSE_MIN + off*100/9 = PULSE_MIN + 11*off + off/9.
  localparam int PULSE_MIN   = 1000000;
  localparam int PULSE_WHOLE = 11;
  localparam int PULSE_DIV   = 9;
  // off/9 is estimated as (off * RECIP_M) >> RECIP_SHIFT, low by at most one.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_M     = (1 << RECIP_SHIFT) / PULSE_DIV;
  localparam int RECIP_BITS  = 17;
  localparam int RP_BITS     = OFF_BITS + RECIP_BITS;
  localparam int Q_BITS      = 14;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAN_GAIN     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TILT_GAIN    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_STEP     = 3'd4;

  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 80;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

endpackage

// ===== design/pan_tilt_tracking_step.sv =====
// Top level of the pan/tilt tracking step: configuration, two axis lanes and the result register.
// Each request carries a target pixel and the measured laser pixel; the pan and tilt lanes
// run side by side and the result register merges both angles and servo pulse widths into
// one result. Each lane takes a request through the multiply, the 28-step restoring divider
// (error times gain over frame size), the clamp and the two pulse-width stages, and then
// hands it over to the result register. A new request is taken as soon as both lanes have
// handed their result to the output register, even if that result is still waiting
// downstream, so no request is accepted while the previous one is still in the lanes.
// Configuration writes are accepted in every cycle; unknown indexes are ignored. The gains
// and the step limit are read part way through an update, so registers should only be
// written while no request is in flight.
`include "assert_macros.svh"

module pan_tilt_tracking_step (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: target_x [11:0], target_y [23:12], laser_x [35:24], laser_y [47:36]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ptt_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // m_tdata: pan_angle_mdeg [16:0], tilt_angle_mdeg [33:17], pan_pulse_ns [54:34],
  //          tilt_pulse_ns [75:55], zero [79:76]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ptt_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ptt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import ptt_pkg::*;

  logic [FRAME_BITS-1:0] img_width;
  logic [FRAME_BITS-1:0] img_height;
  logic [GAIN_BITS-1:0]  pan_scale;
  logic [GAIN_BITS-1:0]  tilt_scale;
  logic [GAIN_BITS-1:0]  max_step;

  logic                         start;
  logic                         take;
  lane_stat_t                   pan_stat;
  lane_stat_t                   tilt_stat;
  logic signed [ANGLE_BITS-1:0] pan_angle;
  logic signed [ANGLE_BITS-1:0] tilt_angle;
  logic [PULSE_BITS-1:0]        pan_pulse;
  logic [PULSE_BITS-1:0]        tilt_pulse;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= FRAME_BITS'(640);
      img_height <= FRAME_BITS'(480);
      pan_scale  <= GAIN_BITS'(16000);
      tilt_scale <= GAIN_BITS'(16000);
      max_step   <= GAIN_BITS'(1800);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  img_width  <= cfg_data[FRAME_BITS-1:0];
        CFG_FRAME_HEIGHT: img_height <= cfg_data[FRAME_BITS-1:0];
        CFG_PAN_GAIN:     pan_scale  <= cfg_data;
        CFG_TILT_GAIN:    tilt_scale <= cfg_data;
        CFG_MAX_STEP:     max_step   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready = pan_stat.idle && tilt_stat.idle;
  assign start    = s_tvalid && s_tready;
  // Both lanes finish in the same cycle; the merge waits for a free output register.
  assign take     = pan_stat.done && tilt_stat.done && (!m_tvalid || m_tready);

  ptt_lane u_pan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .take      (take),
    .frame     (img_width),
    .gain      (pan_scale),
    .max_step  (max_step),
    .tgt       (s_tdata[11:0]),
    .las       (s_tdata[35:24]),
    .angle_out (pan_angle),
    .pulse     (pan_pulse),
    .stat      (pan_stat)
  );

  ptt_lane u_tilt (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .take      (take),
    .frame     (img_height),
    .gain      (tilt_scale),
    .max_step  (max_step),
    .tgt       (s_tdata[23:12]),
    .las       (s_tdata[47:36]),
    .angle_out (tilt_angle),
    .pulse     (tilt_pulse),
    .stat      (tilt_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {4'b0000, tilt_pulse, pan_pulse, tilt_angle, pan_angle};
    end
  end

  `ASSERT_SAME(a_lanes_in_step, clk, rst, 1'b1, pan_stat == tilt_stat, "lanes out of step")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, start, !s_tready, "accepted while busy")
  `ASSERT_SAME(a_angle_range, clk, rst, m_tvalid, ($signed(m_tdata[16:0]) <= 17'sd45000) && ($signed(m_tdata[16:0]) >= -17'sd45000), "pan angle out of range")

endmodule

// ===== design/ptt_lane.sv =====
// One axis lane: proportional step by serial division, slew and angle clamp, pulse width.
module ptt_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               take,
  input  logic [ptt_pkg::FRAME_BITS-1:0]     frame,
  input  logic [ptt_pkg::GAIN_BITS-1:0]      gain,
  input  logic [ptt_pkg::GAIN_BITS-1:0]      max_step,
  input  logic [ptt_pkg::COORD_BITS-1:0]     tgt,
  input  logic [ptt_pkg::COORD_BITS-1:0]     las,
  output logic signed [ptt_pkg::ANGLE_BITS-1:0] angle_out,
  output logic [ptt_pkg::PULSE_BITS-1:0]     pulse,
  output ptt_pkg::lane_stat_t                stat
);
  import ptt_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MUL  = 3'd1;
  localparam logic [2:0] L_DIV  = 3'd2;
  localparam logic [2:0] L_STEP = 3'd3;
  localparam logic [2:0] L_PDIV = 3'd4;
  localparam logic [2:0] L_PSUM = 3'd5;
  localparam logic [2:0] L_DONE = 3'd6;

  localparam logic signed [SUM_BITS-1:0] LIM_HI = SUM_BITS'(ANGLE_LIMIT);
  localparam logic signed [SUM_BITS-1:0] LIM_LO = -LIM_HI;

  logic [2:0]                   state;
  logic [CNT_BITS-1:0]          cnt;
  logic [COORD_BITS-1:0]        mag_r;
  logic                         neg_r;
  logic [FRAME_BITS-1:0]        divisor;
  logic [PROD_BITS-1:0]         acc;
  logic [FRAME_BITS-1:0]        rem;
  logic signed [ANGLE_BITS-1:0] angle;
  logic [OFF_BITS-1:0]          off;
  logic [RP_BITS-1:0]           rprod;

  logic signed [COORD_BITS:0]   err;
  logic [COORD_BITS-1:0]        mag;
  logic [FRAME_BITS:0]          rem_sh;
  logic                         ge;
  logic [GAIN_BITS-1:0]         step_mag;
  logic signed [SUM_BITS-1:0]   step_ext;
  logic signed [SUM_BITS-1:0]   angle_ext;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [SUM_BITS-1:0]   sum_c;
  logic [Q_BITS-1:0]            q0;
  logic [OFF_BITS-1:0]          nine_q;
  logic [OFF_BITS-1:0]          rem9;
  logic [Q_BITS-1:0]            q9;
  logic [PULSE_BITS-1:0]        pulse_c;

  assign err = $signed({1'b0, tgt}) - $signed({1'b0, las});
  assign mag = err[COORD_BITS] ? COORD_BITS'(-err) : err[COORD_BITS-1:0];

  // One restoring division step: the remainder always stays below the divisor.
  assign rem_sh = {rem, acc[PROD_BITS-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  assign step_mag  = (acc > PROD_BITS'(max_step)) ? max_step : acc[GAIN_BITS-1:0];
  assign step_ext  = $signed({{(SUM_BITS-GAIN_BITS){1'b0}}, step_mag});
  assign angle_ext = SUM_BITS'(angle);
  assign sum       = neg_r ? (angle_ext - step_ext) : (angle_ext + step_ext);

  always_comb begin
    if (sum > LIM_HI) begin
      sum_c = LIM_HI;
    end else if (sum < LIM_LO) begin
      sum_c = LIM_LO;
    end else begin
      sum_c = sum;
    end
  end

  assign q0      = rprod[RECIP_SHIFT +: Q_BITS];
  assign nine_q  = OFF_BITS'(q0) * OFF_BITS'(PULSE_DIV);
  assign rem9    = off - nine_q;
  assign q9      = (rem9 >= OFF_BITS'(PULSE_DIV)) ? (q0 + Q_BITS'(1)) : q0;
  assign pulse_c = PULSE_BITS'(PULSE_MIN) + PULSE_BITS'(off) * PULSE_BITS'(PULSE_WHOLE)
                 + PULSE_BITS'(q9);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      angle <= '0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            state <= L_MUL;
          end
        end
        L_MUL: begin
          state <= L_DIV;
        end
        L_DIV: begin
          if (cnt == '0) begin
            state <= L_STEP;
          end
        end
        L_STEP: begin
          angle <= ANGLE_BITS'(sum_c);
          state <= L_PDIV;
        end
        L_PDIV: begin
          state <= L_PSUM;
        end
        L_PSUM: begin
          state <= L_DONE;
        end
        L_DONE: begin
          if (take) begin
            state <= L_IDLE;
          end
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, loaded by the sequencer state.
  always_ff @(posedge clk) begin
    if (state == L_IDLE && start) begin
      mag_r   <= mag;
      neg_r   <= err[COORD_BITS];
      divisor <= (frame == '0) ? FRAME_BITS'(1) : frame;
    end
    if (state == L_MUL) begin
      acc <= PROD_BITS'(mag_r) * PROD_BITS'(gain);
      rem <= '0;
      cnt <= CNT_BITS'(PROD_BITS - 1);
    end
    if (state == L_DIV) begin
      rem <= ge ? FRAME_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[FRAME_BITS-1:0];
      acc <= {acc[PROD_BITS-2:0], ge};
      cnt <= cnt - CNT_BITS'(1);
    end
    if (state == L_STEP) begin
      off <= OFF_BITS'(sum_c + LIM_HI);
    end
    if (state == L_PDIV) begin
      rprod <= RP_BITS'(off) * RP_BITS'(RECIP_M);
    end
    if (state == L_PSUM) begin
      pulse <= pulse_c;
    end
  end

  assign angle_out = angle;
  assign stat.idle = (state == L_IDLE);
  assign stat.done = (state == L_DONE);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the pan/tilt tracking step: stream requests against a predicted servo state.
module tb_top;
  import ptt_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
  localparam int MAX_COORD = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [ANGLE_BITS-1:0] pan;
    logic signed [ANGLE_BITS-1:0] tilt;
    logic [PULSE_BITS-1:0]        pan_pulse;
    logic [PULSE_BITS-1:0]        tilt_pulse;
  } servo_t;

  typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [CFG_DATA_BITS-1:0]  val;
    logic [IN_DATA_BITS-1:0]   item;
    bit                        typed;
    servo_t                    want;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_DATA_BITS-1:0]    s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]   m_tdata;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  // Predicted servo state and register copy.
  int               pan_mdeg = 0;
  int               tilt_mdeg = 0;
  logic [11:0]      frame_w = 12'd640;
  logic [11:0]      frame_h = 12'd480;
  logic [15:0]      gain_pan = 16'd16000;
  logic [15:0]      gain_tilt = 16'd16000;
  logic [15:0]      step_cap = 16'd1800;

  servo_t awaited[$];
  servo_t seen;
  int fail_count = 0;
  int req_count = 0;
  int res_count = 0;
  int write_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  pan_tilt_tracking_step uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int axis_target(int angle, int tgt, int las, int gain, int frame);
    longint err, mag, div, stp, lim, sum;
    err = longint'(tgt) - longint'(las);
    mag = (err < 0) ? -err : err;
    div = (frame == 0) ? 1 : frame;
    stp = (mag * gain) / div;
    if (err < 0) stp = -stp;
    lim = step_cap;
    if (stp > lim) stp = lim;
    if (stp < -lim) stp = -lim;
    sum = angle + stp;
    if (sum > ANGLE_LIMIT) sum = ANGLE_LIMIT;
    if (sum < -ANGLE_LIMIT) sum = -ANGLE_LIMIT;
    return int'(sum);
  endfunction

  // Pulse width rounds down: 1 ms at -45 degrees up to 2 ms at +45 degrees.
  function automatic logic [PULSE_BITS-1:0] pulse_for(int angle);
    longint off;
    off = longint'(angle) + ANGLE_LIMIT;
    return PULSE_BITS'(longint'(PULSE_MIN) + (off * 100) / 9);
  endfunction

  function automatic servo_t advance_tracker(logic [IN_DATA_BITS-1:0] item);
    servo_t r;
    pan_mdeg  = axis_target(pan_mdeg, int'(item[11:0]), int'(item[35:24]),
                            int'(gain_pan), int'(frame_w));
    tilt_mdeg = axis_target(tilt_mdeg, int'(item[23:12]), int'(item[47:36]),
                            int'(gain_tilt), int'(frame_h));
    r.pan        = ANGLE_BITS'(pan_mdeg);
    r.tilt       = ANGLE_BITS'(tilt_mdeg);
    r.pan_pulse  = pulse_for(pan_mdeg);
    r.tilt_pulse = pulse_for(tilt_mdeg);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] val);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.val   = val;
    r.item  = '0;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t item_row(int tx, int ty, int lx, int ly);
    stim_row_t r;
    r.kind  = ROW_ITEM;
    r.idx   = '0;
    r.val   = '0;
    r.item  = {12'(ly), 12'(lx), 12'(ty), 12'(tx)};
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t known_row(int tx, int ty, int lx, int ly,
                                          int pan, int tilt, int ppulse, int tpulse);
    stim_row_t r;
    r = item_row(tx, ty, lx, ly);
    r.typed           = 1'b1;
    r.want.pan        = ANGLE_BITS'(pan);
    r.want.tilt       = ANGLE_BITS'(tilt);
    r.want.pan_pulse  = PULSE_BITS'(ppulse);
    r.want.tilt_pulse = PULSE_BITS'(tpulse);
    return r;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_frame();
    logic [11:0] f;
    case ($urandom_range(7))
      0: f = 12'd0;
      1: f = 12'd1;
      2: f = 12'(MAX_COORD);
      default: f = 12'($urandom_range(MAX_COORD, 64));
    endcase
    // The upper nibble is outside the register and must be dropped.
    return {4'($urandom_range(15)), f};
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(40000));
    endcase
  endfunction

  function automatic logic [11:0] near_coord(logic [11:0] c);
    int v;
    v = int'(c) + int'($urandom_range(128)) - 64;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return 12'(v);
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    fail_count++;
    if (fail_count <= 40)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // The request stays valid after acceptance until the next call replaces or lowers it.
  task automatic send_request(input logic [IN_DATA_BITS-1:0] item, input bit typed,
                              input servo_t known);
    servo_t guess;
    cfg_valid = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = item;
    do @(posedge clk); while (!s_tready);
    guess = advance_tracker(item);
    awaited.push_back(typed ? known : guess);
    req_count++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid  = 1'b0;
    cfg_valid = 1'b0;
    while (awaited.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  frame_w   = val[11:0];
      CFG_FRAME_HEIGHT: frame_h   = val[11:0];
      CFG_PAN_GAIN:     gain_pan  = val;
      CFG_TILT_GAIN:    gain_tilt = val;
      CFG_MAX_STEP:     step_cap  = val;
      default: ;
    endcase
    write_count++;
    @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    logic [11:0] tx, ty, lx, ly;
    int mode;
    servo_t unused;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        wait_for_results();
        write_reg(CFG_FRAME_WIDTH, pick_frame());
        write_reg(CFG_FRAME_HEIGHT, pick_frame());
        write_reg(CFG_PAN_GAIN, pick_gain());
        write_reg(CFG_TILT_GAIN, pick_gain());
        case ($urandom_range(5))
          0: write_reg(CFG_MAX_STEP, 16'd0);
          1: write_reg(CFG_MAX_STEP, 16'(ANGLE_LIMIT));
          2: write_reg(CFG_MAX_STEP, 16'hFFFF);
          default: write_reg(CFG_MAX_STEP, 16'($urandom_range(5000)));
        endcase
        if ($urandom_range(3) == 0)
          write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
      end
      mode = $urandom_range(9);
      tx = 12'($urandom_range(MAX_COORD));
      ty = 12'($urandom_range(MAX_COORD));
      lx = 12'($urandom_range(MAX_COORD));
      ly = 12'($urandom_range(MAX_COORD));
      if (mode >= 5 && mode <= 7) begin
        // Laser close to the target: small errors, within 64 pixels on each axis.
        lx = near_coord(tx);
        ly = near_coord(ty);
      end else if (mode >= 8) begin
        tx = $urandom_range(1) ? 12'(MAX_COORD) : 12'd0;
        ty = $urandom_range(1) ? 12'(MAX_COORD) : 12'd0;
        lx = $urandom_range(1) ? 12'(MAX_COORD) : 12'd0;
        ly = $urandom_range(1) ? 12'(MAX_COORD) : 12'd0;
      end
      send_request({ly, lx, ty, tx}, 1'b0, unused);
    end
    wait_for_results();
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is asked for.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      res_count++;
      if (awaited.size() == 0) begin
        report("result with no request pending", $signed(m_tdata[16:0]), 0);
      end else begin
        seen = awaited.pop_front();
        if (m_tdata[16:0] !== seen.pan)
          report("pan angle", $signed(m_tdata[16:0]), seen.pan);
        if (m_tdata[33:17] !== seen.tilt)
          report("tilt angle", $signed(m_tdata[33:17]), seen.tilt);
        if (m_tdata[54:34] !== seen.pan_pulse)
          report("pan pulse", m_tdata[54:34], seen.pan_pulse);
        if (m_tdata[75:55] !== seen.tilt_pulse)
          report("tilt pulse", m_tdata[75:55], seen.tilt_pulse);
        if (m_tdata[79:76] !== 4'd0)
          report("padding bits", m_tdata[79:76], 0);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results outstanding.", awaited.size());
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    servo_t unused;
    // Centred start, full-scale errors against the default slew limit.
    rows.push_back(known_row(0, 0, 0, 0, 0, 0, 1500000, 1500000));
    rows.push_back(known_row(4095, 4095, 0, 0, 1800, 1800, 1520000, 1520000));
    rows.push_back(known_row(0, 0, 4095, 4095, 0, 0, 1500000, 1500000));
    rows.push_back(item_row(700, 100, 650, 300));
    // A step limit beyond the angle range: the angle clamp takes over.
    rows.push_back(cfg_row(CFG_MAX_STEP, 16'hFFFF));
    rows.push_back(known_row(4095, 4095, 0, 0, 45000, 45000, 2000000, 2000000));
    rows.push_back(item_row(0, 0, 4095, 4095));
    rows.push_back(known_row(0, 0, 4095, 4095, -45000, -45000, 1000000, 1000000));
    // A zero frame width divides by one.
    rows.push_back(cfg_row(CFG_FRAME_WIDTH, 16'd0));
    rows.push_back(cfg_row(CFG_PAN_GAIN, 16'hFFFF));
    rows.push_back(item_row(1, 0, 0, 4095));
    rows.push_back(cfg_row(CFG_TILT_GAIN, 16'd0));
    rows.push_back(item_row(0, 4095, 4095, 0));
    rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 16'd4095));
    rows.push_back(cfg_row(CFG_SPARE_LO, 16'hFFFF));
    rows.push_back(cfg_row(CFG_SPARE_HI, 16'h0001));
    rows.push_back(cfg_row(CFG_MAX_STEP, 16'd0));
    rows.push_back(item_row(4095, 0, 0, 4095));
    rows.push_back(cfg_row(CFG_FRAME_WIDTH, 16'hF280));
    rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 16'd480));
    rows.push_back(cfg_row(CFG_PAN_GAIN, 16'd16000));
    rows.push_back(cfg_row(CFG_TILT_GAIN, 16'd16000));
    rows.push_back(cfg_row(CFG_MAX_STEP, 16'(ANGLE_LIMIT)));
    rows.push_back(item_row(2730, 1365, 1365, 2730));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 26;
    recv_idle_pct = 63;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_for_results();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_request(rows[i].item, rows[i].typed, rows[i].want);
      end
    end

    // Hold the output off so the block fills and stalls its request side.
    wait_for_results();
    send_idle_pct = 0;
    hold_asks++;
    repeat (12) send_request(IN_DATA_BITS'({$urandom, $urandom}), 1'b0, unused);
    wait_for_results();

    run_phase(26, 63, 230);
    run_phase(63, 26, 230);
    run_phase(0, 0, 230);

    wait_for_results();
    repeat (50) @(negedge clk);

    $display("Sent %0d requests, checked %0d results, made %0d register writes;",
             req_count, res_count, write_count);
    $display("slew and angle clamps, zero gain and frame, and three idling mixes exercised.");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
